### src/rrss_pkg.sv
// shared types and constants for the range reverse sum sequence unit
`default_nettype none
package rrss_pkg;
   localparam int MaxElements = 4096;
   localparam int AddrWidth = $clog2(MaxElements);
   localparam int LenWidth = AddrWidth + 1;
   localparam int ValueWidth = 32;
   localparam int SumWidth = 44;

   localparam logic [1:0] OpLoad = 2'd0;
   localparam logic [1:0] OpReverse = 2'd1;
   localparam logic [1:0] OpSum = 2'd2;

   typedef struct packed {
      logic [1:0] operation;
      logic [AddrWidth-1:0] range_start;
      logic [LenWidth-1:0] range_end;
      logic signed [ValueWidth-1:0] load_value;
   } req_type;

   typedef struct packed {
      logic signed [SumWidth-1:0] range_sum;
      logic status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_LO,
      ST_RD_HI,
      ST_WR_LO,
      ST_WR_HI,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_DONE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic load_write;
      logic read_lo;
      logic read_hi;
      logic hold_lo;
      logic write_lo;
      logic write_hi;
      logic step;
      logic acc_clear;
      logic acc_add;
      logic respond;
      logic reject;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic bad;
      logic [1:0] operation;
      logic more;
   } stat_type;
endpackage
`default_nettype wire

### src/rrss_ram.sv
// generic single port ram with registered read
`default_nettype none
module rrss_ram #(
   parameter int Width = 32,
   parameter int Depth = 4096
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(Depth)-1:0] addr,
   input wire logic [Width-1:0] wr_data,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   // write or registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule
`default_nettype wire

### src/rrss_ctrl.sv
// controller state machine for load, reverse and sum
`default_nettype none
module rrss_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   output rrss_pkg::cmd_type cmd,
   input wire rrss_pkg::stat_type stat
);
   rrss_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = (state_ff != rrss_pkg::ST_IDLE);
      case (state_ff)
         rrss_pkg::ST_IDLE: begin
            // capture the item, decode it in the next cycle
            if (start) begin
               cmd.capture = 1'b1;
               state_in = rrss_pkg::ST_DONE;
            end
         end
         rrss_pkg::ST_DONE: begin
            // dispatch on captured item
            if (stat.bad) begin
               cmd.respond = 1'b1;
               cmd.reject = 1'b1;
               state_in = rrss_pkg::ST_IDLE;
            end else if (stat.operation == rrss_pkg::OpLoad) begin
               cmd.load_write = 1'b1;
               cmd.respond = 1'b1;
               state_in = rrss_pkg::ST_IDLE;
            end else if (stat.operation == rrss_pkg::OpReverse) begin
               if (stat.more) begin
                  cmd.read_lo = 1'b1;
                  state_in = rrss_pkg::ST_RD_LO;
               end else begin
                  cmd.respond = 1'b1;
                  state_in = rrss_pkg::ST_IDLE;
               end
            end else begin
               cmd.acc_clear = 1'b1;
               cmd.read_lo = 1'b1;
               state_in = rrss_pkg::ST_SUM_RD;
            end
         end
         rrss_pkg::ST_RD_LO: begin
            // low element is on the read port now
            cmd.hold_lo = 1'b1;
            cmd.read_hi = 1'b1;
            state_in = rrss_pkg::ST_RD_HI;
         end
         rrss_pkg::ST_RD_HI: begin
            cmd.write_lo = 1'b1;
            state_in = rrss_pkg::ST_WR_LO;
         end
         rrss_pkg::ST_WR_LO: begin
            cmd.write_hi = 1'b1;
            cmd.step = 1'b1;
            state_in = rrss_pkg::ST_WR_HI;
         end
         rrss_pkg::ST_WR_HI: begin
            if (stat.more) begin
               cmd.read_lo = 1'b1;
               state_in = rrss_pkg::ST_RD_LO;
            end else begin
               cmd.respond = 1'b1;
               state_in = rrss_pkg::ST_IDLE;
            end
         end
         rrss_pkg::ST_SUM_RD: begin
            cmd.step = 1'b1;
            state_in = rrss_pkg::ST_SUM_ACC;
         end
         rrss_pkg::ST_SUM_ACC: begin
            cmd.acc_add = 1'b1;
            if (stat.more) begin
               cmd.read_lo = 1'b1;
               state_in = rrss_pkg::ST_SUM_RD;
            end else begin
               state_in = rrss_pkg::ST_IDLE;
               cmd.respond = 1'b1;
            end
         end
         default: state_in = rrss_pkg::ST_IDLE;
      endcase
   end

   // a new item is only taken when idle
   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> state_ff == rrss_pkg::ST_IDLE)
      else $error("capture outside idle");
   // exactly one response per dispatch path ends in idle
   assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> state_ff == rrss_pkg::ST_IDLE)
      else $error("response without return to idle");
   // writes never overlap
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.write_lo && cmd.write_hi) && !(cmd.load_write && cmd.write_hi))
      else $error("overlapping writes");
endmodule
`default_nettype wire

### src/rrss_dp.sv
// datapath: item registers, address pointers, element memory and accumulator
`default_nettype none
module rrss_dp (
   input wire logic clock,
   input wire logic [rrss_pkg::LenWidth-1:0] csr_sequence_length,
   input wire rrss_pkg::req_type req_item,
   input wire rrss_pkg::cmd_type cmd,
   output rrss_pkg::stat_type stat,
   output logic rsp_valid_in,
   output rrss_pkg::rsp_type rsp_item_in
);
   localparam int AW = rrss_pkg::AddrWidth;
   localparam int LW = rrss_pkg::LenWidth;

   rrss_pkg::req_type item_ff;
   logic [LW-1:0] len_ff;
   logic [AW-1:0] lo_ff, hi_ff;
   logic [rrss_pkg::ValueWidth-1:0] hold_ff;
   logic signed [rrss_pkg::SumWidth-1:0] acc_ff;
   logic [AW-1:0] addr;
   logic wr_en;
   logic [rrss_pkg::ValueWidth-1:0] wr_data, rd_data;
   logic [LW-1:0] len_eff;

   // length clamped to the store size
   assign len_eff = (csr_sequence_length > LW'(rrss_pkg::MaxElements)) ?
      LW'(rrss_pkg::MaxElements) : csr_sequence_length;

   // item capture and pointers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_item;
         len_ff <= len_eff;
         lo_ff <= req_item.range_start;
         hi_ff <= AW'(req_item.range_end - LW'(1));
      end else if (cmd.step) begin
         lo_ff <= lo_ff + AW'(1);
         hi_ff <= hi_ff - AW'(1);
      end
      if (cmd.hold_lo) begin
         hold_ff <= rd_data;
      end
      if (cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + rrss_pkg::SumWidth'(signed'(rd_data));
      end
   end

   // validity of the captured item
   always_comb begin
      stat.operation = item_ff.operation;
      case (item_ff.operation)
         rrss_pkg::OpLoad:
            stat.bad = {1'b0, item_ff.range_start} >= len_ff;
         rrss_pkg::OpReverse, rrss_pkg::OpSum:
            stat.bad = ({1'b0, item_ff.range_start} >= item_ff.range_end) ||
               (item_ff.range_end > len_ff);
         default: stat.bad = 1'b1;
      endcase
      // reverse continues while lo < hi; sum until lo reaches end modulo the store size
      if (item_ff.operation == rrss_pkg::OpSum) begin
         stat.more = lo_ff != item_ff.range_end[AW-1:0];
      end else begin
         stat.more = lo_ff < hi_ff;
      end
   end

   // memory port steering
   always_comb begin
      addr = lo_ff;
      wr_en = 1'b0;
      wr_data = rd_data;
      if (cmd.load_write) begin
         addr = item_ff.range_start;
         wr_en = 1'b1;
         wr_data = item_ff.load_value;
      end else if (cmd.read_lo) begin
         addr = lo_ff;
      end else if (cmd.read_hi) begin
         addr = hi_ff;
      end else if (cmd.write_lo) begin
         addr = lo_ff;
         wr_en = 1'b1;
         wr_data = rd_data;
      end else if (cmd.write_hi) begin
         addr = hi_ff;
         wr_en = 1'b1;
         wr_data = hold_ff;
      end
   end

   rrss_ram #(.Width(rrss_pkg::ValueWidth), .Depth(rrss_pkg::MaxElements)) u_store (
      .clock(clock),
      .wr_en(wr_en),
      .addr(addr),
      .wr_data(wr_data),
      .rd_data(rd_data)
   );

   // result formation
   always_comb begin
      rsp_valid_in = cmd.respond;
      rsp_item_in.status = cmd.reject;
      rsp_item_in.range_sum = (!cmd.reject && item_ff.operation == rrss_pkg::OpSum) ?
         (cmd.acc_add ? acc_ff + rrss_pkg::SumWidth'(signed'(rd_data)) : acc_ff) : '0;
   end
endmodule
`default_nettype wire

### src/range_reverse_sum_sequence_unit.sv
// top level of the range reverse sum sequence unit
// One item at a time: busy is high from acceptance until the result strobe.
// A load or rejected item is captured, then answered in the done state. A
// reverse swaps pairs via the read-lo, read-hi, write-lo and write-hi states,
// a sum each position via sum-read and sum-acc, as the memory has one port. The
// result is shown for one cycle with rsp_valid; the receiver cannot stall it.
// Positions read before being loaded give undefined values.
`default_nettype none
module range_reverse_sum_sequence_unit (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire rrss_pkg::req_type req_item,
   output logic rsp_valid,
   output rrss_pkg::rsp_type rsp_item,
   input wire logic csr_write_en,
   input wire logic [rrss_pkg::LenWidth-1:0] csr_write_data
);
   logic [rrss_pkg::LenWidth-1:0] len_ff;
   rrss_pkg::cmd_type cmd;
   rrss_pkg::stat_type stat;
   logic valid_in;
   rrss_pkg::rsp_type item_in;

   // length register
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= rrss_pkg::LenWidth'(rrss_pkg::MaxElements);
      end else if (csr_write_en) begin
         len_ff <= csr_write_data;
      end
   end

   rrss_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .cmd(cmd), .stat(stat)
   );

   rrss_dp u_dp (
      .clock(clock), .csr_sequence_length(len_ff), .req_item(req_item),
      .cmd(cmd), .stat(stat), .rsp_valid_in(valid_in), .rsp_item_in(item_in)
   );

   // result strobe is the response command itself
   assign rsp_valid = valid_in;
   assign rsp_item = item_in;
endmodule
`default_nettype wire
